[rtl/core/bmf_pkg.sv]
// bmf_pkg: shared constants for the box mean filter
// no dependencies; used by bmf_div, box_mean_filter_clipped_edges, bmf_checker and tb
package bmf_pkg;

  localparam int unsigned MAX_RADIUS_DEF = 8;
  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_HEIGHT_DEF = 1024;

  localparam int unsigned NUM_CH  = 3;
  localparam int unsigned CH_W    = 16;
  localparam int unsigned POS_W   = 10;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 11;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

endpackage

[rtl/core/box_mean_filter_clipped_edges.sv]
// box_mean_filter_clipped_edges: clipped square mean filter over an rgb stream
// depends on bmf_pkg and bmf_div
//
//  port group   direction  handshake                 payload
//  in           input      in_valid_i / in_stall_o   action, in_red/green/blue
//  out          output     out_valid_o / out_stall_i out_red/green/blue, column, row, frame_end
//  cfg          input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// an item that makes no result only writes the row store at acceptance
// an item that makes a result stalls the input through setup, the window reads (one per
//   window pixel, through the one read port of the row store), flush, divider start,
//   the restoring divider run over QW quotient bits, QW = 26 by default, and the result state
// reset clears positions and control; the row store holds nothing defined until written
// the next transaction is taken while a result still waits in the output register;
//   a result finishing while that register is stalled waits in the result state
module box_mean_filter_clipped_edges #(
  parameter int unsigned MAX_RADIUS = bmf_pkg::MAX_RADIUS_DEF,
  parameter int unsigned MAX_WIDTH  = bmf_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = bmf_pkg::MAX_HEIGHT_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input stream
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             action_i,
  input  logic [bmf_pkg::CH_W-1:0]         in_red_i,
  input  logic [bmf_pkg::CH_W-1:0]         in_green_i,
  input  logic [bmf_pkg::CH_W-1:0]         in_blue_i,
  // output stream
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [bmf_pkg::CH_W-1:0]         out_red_o,
  output logic [bmf_pkg::CH_W-1:0]         out_green_o,
  output logic [bmf_pkg::CH_W-1:0]         out_blue_o,
  output logic [bmf_pkg::POS_W-1:0]        out_column_o,
  output logic [bmf_pkg::POS_W-1:0]        out_row_o,
  output logic                             frame_end_o,
  // configuration
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [bmf_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [bmf_pkg::CFG_DAT_W-1:0]    cfg_data_i
);

  localparam int unsigned SPAN_MAX = 2 * MAX_RADIUS + 1;
  localparam int unsigned DEPTH    = SPAN_MAX * MAX_WIDTH;
  localparam int unsigned AW       = $clog2(DEPTH);
  localparam int unsigned CW       = $clog2(MAX_WIDTH);
  localparam int unsigned RWW      = $clog2(MAX_HEIGHT + MAX_RADIUS + 2);
  localparam int unsigned MW       = $clog2(SPAN_MAX);
  localparam int unsigned GW0      = $clog2(MAX_WIDTH + MAX_HEIGHT + 64);
  localparam int unsigned GW       = (GW0 > 11) ? GW0 : 11;
  localparam int unsigned NW       = $clog2(SPAN_MAX * SPAN_MAX + 1);
  localparam int unsigned SW       = bmf_pkg::CH_W + NW;
  localparam int unsigned QW       = SW + 1;
  localparam int unsigned PW       = bmf_pkg::NUM_CH * bmf_pkg::CH_W;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SETUP, ST_READ, ST_FLUSH, ST_DIVS, ST_DIVW, ST_RES
  } state_e;

  // configuration registers
  logic [3:0]                      radius_q;
  logic [bmf_pkg::CFG_DAT_W-1:0]   fw_q, fh_q;

  // effective geometry
  logic [GW-1:0] fw_g, fh_g, ew, eh, er, span, rl;

  always_comb begin
    fw_g = GW'(fw_q);
    fh_g = GW'(fh_q);
    ew   = (fw_g == '0) ? GW'(1) : ((fw_g > GW'(MAX_WIDTH)) ? GW'(MAX_WIDTH) : fw_g);
    eh   = (fh_g == '0) ? GW'(1) : ((fh_g > GW'(MAX_HEIGHT)) ? GW'(MAX_HEIGHT) : fh_g);
    rl   = GW'(radius_q);
    er   = (rl > GW'(MAX_RADIUS)) ? GW'(MAX_RADIUS) : rl;
    if (er > ((ew - GW'(1)) >> 1)) er = (ew - GW'(1)) >> 1;
    if (er > ((eh - GW'(1)) >> 1)) er = (eh - GW'(1)) >> 1;
    span = (er << 1) + GW'(1);
  end

  // stream positions: input and output as row/column, plus row index inside the store
  logic [CW-1:0]  in_col_q, out_col_q;
  logic [RWW-1:0] in_row_q, out_row_q;
  logic [MW-1:0]  in_mod_q, out_mod_q;

  // window walk
  logic [CW-1:0]  x0_q, x1_q, rd_col_q;
  logic [RWW-1:0] y1_q, rd_row_q;
  logic [MW-1:0]  rd_mod_q;
  logic           rd_v_q;

  logic [bmf_pkg::NUM_CH-1:0][SW-1:0] sum_q;
  logic [NW-1:0]                      n_q;

  state_e state_q;

  // row store
  logic [PW-1:0] mem [DEPTH];
  logic [PW-1:0] rdata_q;
  logic [AW-1:0] waddr, raddr;
  logic          in_acc, in_pix_part, in_lag, mem_we;
  logic [PW-1:0] wdata;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign in_pix_part = (GW'(in_row_q) < eh);
  assign in_lag      = (GW'(in_row_q) < er) ||
                       ((GW'(in_row_q) == er) && (GW'(in_col_q) < er));
  assign mem_we      = in_acc && in_pix_part;
  assign wdata       = action_i ? '0 : {in_blue_i, in_green_i, in_red_i};
  assign waddr       = AW'(in_mod_q) * AW'(MAX_WIDTH) + AW'(in_col_q);
  assign raddr       = AW'(rd_mod_q) * AW'(MAX_WIDTH) + AW'(rd_col_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_READ) rdata_q <= mem[raddr];
  end

  // window bounds around the current output pixel
  logic [GW-1:0] yg, xg, ymod, y0, y1, x0, x1, y0mod;
  always_comb begin
    yg   = GW'(out_row_q);
    xg   = GW'(out_col_q);
    ymod = GW'(out_mod_q);
    y0   = (yg >= er) ? yg - er : '0;
    y1   = (yg + er < eh) ? yg + er : eh - GW'(1);
    x0   = (xg >= er) ? xg - er : '0;
    x1   = (xg + er < ew) ? xg + er : ew - GW'(1);
    if (yg < er)          y0mod = '0;
    else if (ymod >= er)  y0mod = ymod - er;
    else                  y0mod = ymod + span - er;
  end

  // divider
  logic                                 div_start, div_done;
  logic [bmf_pkg::NUM_CH-1:0][QW-1:0]   div_num, div_quo;

  always_comb begin
    for (int c = 0; c < bmf_pkg::NUM_CH; c++) begin
      div_num[c] = QW'(sum_q[c]) + QW'(n_q >> 1);
    end
  end
  assign div_start = (state_q == ST_DIVS);

  bmf_div #(
    .NUM_W (QW),
    .DEN_W (NW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (n_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  logic is_last, out_free, frame_last;
  assign is_last    = (rd_col_q == x1_q) && (rd_row_q == y1_q);
  assign out_free   = !out_valid_o || !out_stall_i;
  assign frame_last = (GW'(out_row_q) == eh - GW'(1)) && (GW'(out_col_q) == ew - GW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      radius_q     <= 4'd2;
      fw_q         <= bmf_pkg::CFG_DAT_W'(1024);
      fh_q         <= bmf_pkg::CFG_DAT_W'(1024);
      in_col_q     <= '0;
      in_row_q     <= '0;
      in_mod_q     <= '0;
      out_col_q    <= '0;
      out_row_q    <= '0;
      out_mod_q    <= '0;
      x0_q         <= '0;
      x1_q         <= '0;
      y1_q         <= '0;
      rd_col_q     <= '0;
      rd_row_q     <= '0;
      rd_mod_q     <= '0;
      rd_v_q       <= 1'b0;
      sum_q        <= '0;
      n_q          <= '0;
      out_valid_o  <= 1'b0;
      out_red_o    <= '0;
      out_green_o  <= '0;
      out_blue_o   <= '0;
      out_column_o <= '0;
      out_row_o    <= '0;
      frame_end_o  <= 1'b0;
    end else begin
      // output register drains independently; the result state refills it itself
      if (out_valid_o && !out_stall_i && (state_q != ST_RES)) out_valid_o <= 1'b0;

      // accumulate read data in the cycle after the read
      rd_v_q <= (state_q == ST_READ);
      if (rd_v_q) begin
        for (int c = 0; c < bmf_pkg::NUM_CH; c++) begin
          sum_q[c] <= sum_q[c] + SW'(rdata_q[c*bmf_pkg::CH_W +: bmf_pkg::CH_W]);
        end
        n_q <= n_q + NW'(1);
      end

      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_lag) begin
              if (GW'(in_col_q) == ew - GW'(1)) begin
                in_col_q <= '0;
                in_row_q <= in_row_q + RWW'(1);
                in_mod_q <= (GW'(in_mod_q) == span - GW'(1)) ? '0 : in_mod_q + MW'(1);
              end else begin
                in_col_q <= in_col_q + CW'(1);
              end
            end else begin
              state_q <= ST_SETUP;
            end
          end
        end
        ST_SETUP: begin
          x0_q     <= CW'(x0);
          x1_q     <= CW'(x1);
          y1_q     <= RWW'(y1);
          rd_col_q <= CW'(x0);
          rd_row_q <= RWW'(y0);
          rd_mod_q <= MW'(y0mod);
          sum_q    <= '0;
          n_q      <= '0;
          state_q  <= ST_READ;
        end
        ST_READ: begin
          // walk the clipped window in raster order, one store read a cycle
          if (is_last) begin
            state_q <= ST_FLUSH;
          end else if (rd_col_q == x1_q) begin
            rd_col_q <= x0_q;
            rd_row_q <= rd_row_q + RWW'(1);
            rd_mod_q <= (GW'(rd_mod_q) == span - GW'(1)) ? '0 : rd_mod_q + MW'(1);
          end else begin
            rd_col_q <= rd_col_q + CW'(1);
          end
        end
        ST_FLUSH: begin
          // last read word is summed at this edge
          state_q <= ST_DIVS;
        end
        ST_DIVS: begin
          state_q <= ST_DIVW;
        end
        ST_DIVW: begin
          if (div_done) state_q <= ST_RES;
        end
        ST_RES: begin
          if (out_free) begin
            out_valid_o  <= 1'b1;
            out_red_o    <= div_quo[0][bmf_pkg::CH_W-1:0];
            out_green_o  <= div_quo[1][bmf_pkg::CH_W-1:0];
            out_blue_o   <= div_quo[2][bmf_pkg::CH_W-1:0];
            out_column_o <= bmf_pkg::POS_W'(out_col_q);
            out_row_o    <= bmf_pkg::POS_W'(out_row_q);
            frame_end_o  <= frame_last;
            state_q      <= ST_IDLE;
            if (frame_last) begin
              // frame done: both positions restart
              in_col_q  <= '0;
              in_row_q  <= '0;
              in_mod_q  <= '0;
              out_col_q <= '0;
              out_row_q <= '0;
              out_mod_q <= '0;
            end else begin
              if (GW'(in_col_q) == ew - GW'(1)) begin
                in_col_q <= '0;
                in_row_q <= in_row_q + RWW'(1);
                in_mod_q <= (GW'(in_mod_q) == span - GW'(1)) ? '0 : in_mod_q + MW'(1);
              end else begin
                in_col_q <= in_col_q + CW'(1);
              end
              if (GW'(out_col_q) == ew - GW'(1)) begin
                out_col_q <= '0;
                out_row_q <= out_row_q + RWW'(1);
                out_mod_q <= (GW'(out_mod_q) == span - GW'(1)) ? '0 : out_mod_q + MW'(1);
              end else begin
                out_col_q <= out_col_q + CW'(1);
              end
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase

      // configuration write to radius, width or height restarts the frame
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          bmf_pkg::CFG_RADIUS: radius_q <= cfg_data_i[3:0];
          bmf_pkg::CFG_WIDTH:  fw_q     <= cfg_data_i;
          bmf_pkg::CFG_HEIGHT: fh_q     <= cfg_data_i;
          default: ;
        endcase
        if (cfg_index_i == bmf_pkg::CFG_RADIUS || cfg_index_i == bmf_pkg::CFG_WIDTH ||
            cfg_index_i == bmf_pkg::CFG_HEIGHT) begin
          in_col_q  <= '0;
          in_row_q  <= '0;
          in_mod_q  <= '0;
          out_col_q <= '0;
          out_row_q <= '0;
          out_mod_q <= '0;
        end
      end
    end
  end

endmodule

[rtl/core/bmf_div.sv]
// bmf_div: three restoring dividers sharing one step counter and divisor
// depends on bmf_pkg
module bmf_div #(
  parameter int unsigned NUM_W = 27,
  parameter int unsigned DEN_W = 10
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic [bmf_pkg::NUM_CH-1:0][NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]                       den_i,
  output logic                                   done_o,
  output logic [bmf_pkg::NUM_CH-1:0][NUM_W-1:0]  quo_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [bmf_pkg::NUM_CH-1:0][NUM_W-1:0] num_q;
  logic [bmf_pkg::NUM_CH-1:0][DEN_W:0]   rem_q;
  logic [DEN_W-1:0]                      den_q;
  logic [CNT_W-1:0]                      cnt_q;
  logic                                  done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [DEN_W:0] sh;
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
      num_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        num_q <= num_i;
        rem_q <= '0;
        den_q <= den_i;
        cnt_q <= CNT_W'(NUM_W);
      end else if (cnt_q != '0) begin
        for (int c = 0; c < bmf_pkg::NUM_CH; c++) begin
          sh = {rem_q[c][DEN_W-1:0], num_q[c][NUM_W-1]};
          if (sh >= {1'b0, den_q}) begin
            rem_q[c] <= sh - {1'b0, den_q};
            num_q[c] <= {num_q[c][NUM_W-2:0], 1'b1};
          end else begin
            rem_q[c] <= sh;
            num_q[c] <= {num_q[c][NUM_W-2:0], 1'b0};
          end
        end
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) done_q <= 1'b1;
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = num_q;

endmodule

[verif/bmf_checker.sv]
// bmf_checker: watches the input, output and config channels of the box mean filter,
// predicts each filtered pixel and compares it field by field; depends on bmf_pkg
`timescale 1ns / 100ps

module bmf_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic                          action_i,
  input  logic [bmf_pkg::CH_W-1:0]      in_red_i,
  input  logic [bmf_pkg::CH_W-1:0]      in_green_i,
  input  logic [bmf_pkg::CH_W-1:0]      in_blue_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [bmf_pkg::CH_W-1:0]      out_red_i,
  input  logic [bmf_pkg::CH_W-1:0]      out_green_i,
  input  logic [bmf_pkg::CH_W-1:0]      out_blue_i,
  input  logic [bmf_pkg::POS_W-1:0]     out_column_i,
  input  logic [bmf_pkg::POS_W-1:0]     out_row_i,
  input  logic                          frame_end_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [bmf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bmf_pkg::CFG_DAT_W-1:0] cfg_data_i,
  output int                            error_count_o,
  output int                            pending_o
);

  localparam int unsigned SPAN_MAX = 2 * bmf_pkg::MAX_RADIUS_DEF + 1;
  localparam int unsigned CHW      = bmf_pkg::CH_W;
  localparam int unsigned MWD      = bmf_pkg::MAX_WIDTH_DEF;

  typedef struct packed {
    logic [CHW-1:0]            red;
    logic [CHW-1:0]            green;
    logic [CHW-1:0]            blue;
    logic [bmf_pkg::POS_W-1:0] column;
    logic [bmf_pkg::POS_W-1:0] row;
    logic                      last;
  } mean_pixel_t;

  mean_pixel_t    mean_q[$];
  bit [3*CHW-1:0] line_buf [SPAN_MAX*MWD];
  logic [3:0]      radius_reg;
  logic [10:0]     width_reg, height_reg;
  int unsigned     in_pos;

  assign pending_o = mean_q.size();

  task automatic settle_geometry(output int unsigned w, output int unsigned h,
                                 output int unsigned r);
    w = (width_reg == 0) ? 1 : (width_reg > MWD) ? MWD : width_reg;
    h = (height_reg == 0) ? 1 :
        (height_reg > bmf_pkg::MAX_HEIGHT_DEF) ? bmf_pkg::MAX_HEIGHT_DEF : height_reg;
    r = (radius_reg > bmf_pkg::MAX_RADIUS_DEF) ? bmf_pkg::MAX_RADIUS_DEF : radius_reg;
    if (r > (w - 1) / 2) r = (w - 1) / 2;
    if (r > (h - 1) / 2) r = (h - 1) / 2;
  endtask

  task automatic accept_pixel(logic drain, logic [3*CHW-1:0] px);
    int unsigned w, h, r, total, lag, span, o, x, y, x0, x1, y0, y1, n;
    int unsigned sum [3];
    mean_pixel_t m;
    settle_geometry(w, h, r);
    total = w * h;
    lag = r * w + r;
    span = 2 * r + 1;
    if (in_pos < total)
      line_buf[((in_pos / w) % span) * MWD + in_pos % w] = drain ? '0 : px;
    if (in_pos < lag) begin
      in_pos++;
      return;
    end
    o = in_pos - lag;
    y = o / w;
    x = o % w;
    y0 = (y >= r) ? y - r : 0;
    y1 = (y + r < h) ? y + r : h - 1;
    x0 = (x >= r) ? x - r : 0;
    x1 = (x + r < w) ? x + r : w - 1;
    sum = '{0, 0, 0};
    for (int unsigned yy = y0; yy <= y1; yy++) begin
      for (int unsigned xx = x0; xx <= x1; xx++) begin
        bit [3*CHW-1:0] v;
        v = line_buf[(yy % span) * MWD + xx];
        sum[0] += v[3*CHW-1:2*CHW];
        sum[1] += v[2*CHW-1:CHW];
        sum[2] += v[CHW-1:0];
      end
    end
    n = (y1 - y0 + 1) * (x1 - x0 + 1);
    m.red    = CHW'((sum[0] + n / 2) / n);
    m.green  = CHW'((sum[1] + n / 2) / n);
    m.blue   = CHW'((sum[2] + n / 2) / n);
    m.column = x[bmf_pkg::POS_W-1:0];
    m.row    = y[bmf_pkg::POS_W-1:0];
    m.last   = (o + 1 >= total);
    mean_q.push_back(m);
    in_pos = m.last ? 0 : in_pos + 1;
  endtask

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      error_count_o++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_reg    <= 4'd2;
      width_reg     <= 11'd1024;
      height_reg    <= 11'd1024;
      in_pos        <= 0;
      error_count_o <= 0;
      mean_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          bmf_pkg::CFG_RADIUS: radius_reg = cfg_data_i[3:0];
          bmf_pkg::CFG_WIDTH:  width_reg  = cfg_data_i;
          bmf_pkg::CFG_HEIGHT: height_reg = cfg_data_i;
          default: ;
        endcase
        if (cfg_index_i inside {bmf_pkg::CFG_RADIUS, bmf_pkg::CFG_WIDTH,
                                bmf_pkg::CFG_HEIGHT}) in_pos = 0;
      end
      if (in_valid_i && !in_stall_i)
        accept_pixel(action_i, {in_red_i, in_green_i, in_blue_i});
      if (out_valid_i && !out_stall_i) begin
        if (mean_q.size() == 0) begin
          error_count_o++;
          $display("%0t: unexpected output pixel, expected none actual col %0d row %0d",
                   $time, out_column_i, out_row_i);
        end else begin
          mean_pixel_t m;
          m = mean_q.pop_front();
          check_field("red", m.red, out_red_i);
          check_field("green", m.green, out_green_i);
          check_field("blue", m.blue, out_blue_i);
          check_field("column", m.column, out_column_i);
          check_field("row", m.row, out_row_i);
          check_field("frame_end", m.last, frame_end_i);
        end
      end
    end
  end

endmodule

[verif/tb.sv]
// tb: stimulus and verdict for the box mean filter; drives frames under random
// config, bursts and output stalls; depends on bmf_pkg, bmf_checker and the block
`timescale 1ns / 100ps

module tb;

  localparam int unsigned CIW = bmf_pkg::CFG_IDX_W;
  localparam int unsigned CDW = bmf_pkg::CFG_DAT_W;
  localparam int unsigned CHW = bmf_pkg::CH_W;
  localparam logic [CIW-1:0] CFG_SPARE = 2'd3;  // unused register slot
  localparam int SETTLE     = 400;    // worst result latency plus margin
  localparam int IDLE_LIMIT = 20000;  // cycles without any transaction
  localparam int ITEM_GOAL  = 1150;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, in_stall;
  logic action = 1'b0;
  logic [CHW-1:0] in_red = '0, in_green = '0, in_blue = '0;
  logic out_valid, out_stall = 1'b0;
  logic [CHW-1:0] out_red, out_green, out_blue;
  logic [bmf_pkg::POS_W-1:0] out_column, out_row;
  logic frame_end;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [CIW-1:0] cfg_index = '0;
  logic [CDW-1:0] cfg_data = '0;
  int errors, pending;
  int idle_cycles = 0;
  int items_sent = 0;
  int burst_left = 0;
  bit radius_max_done = 0;

  box_mean_filter_clipped_edges dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .action_i(action),
    .in_red_i(in_red), .in_green_i(in_green), .in_blue_i(in_blue),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .out_red_o(out_red), .out_green_o(out_green), .out_blue_o(out_blue),
    .out_column_o(out_column), .out_row_o(out_row), .frame_end_o(frame_end),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  bmf_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .action_i(action),
    .in_red_i(in_red), .in_green_i(in_green), .in_blue_i(in_blue),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .out_red_i(out_red), .out_green_i(out_green), .out_blue_i(out_blue),
    .out_column_i(out_column), .out_row_i(out_row), .frame_end_i(frame_end),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .error_count_o(errors), .pending_o(pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver stall pattern: modes of random length, free-flowing, light, heavy
  int stall_mode = 0, stall_left = 0;
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // watchdog: any transaction on any channel counts as progress
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // a transaction is accepted at the posedge after the negedge that sees it free
  task automatic cfg_write(logic [CIW-1:0] idx, logic [CDW-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(negedge clk); while (!cfg_ready);
  endtask

  task automatic cfg_done();
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_pixel(logic drain, logic [CHW-1:0] r, logic [CHW-1:0] g,
                            logic [CHW-1:0] b);
    int gap;
    @(posedge clk);
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
    end
    burst_left--;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= drain;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    items_sent++;
    do @(negedge clk); while (in_stall);
  endtask

  task automatic stream_done();
    @(posedge clk);
    in_valid <= 1'b0;
  endtask

  // block is idle once every result is out and a worst-case result has had time
  task automatic drain_wait();
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [CHW-1:0] pick_channel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return CHW'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  task automatic configure(int r, int w, int h);
    int order;
    order = $urandom_range(0, 2);
    // spare index occasionally, it must leave the frame alone
    if ($urandom_range(0, 3) == 0) cfg_write(CFG_SPARE, CDW'($urandom_range(0, 11'h7FF)));
    if (order == 0) begin
      cfg_write(bmf_pkg::CFG_RADIUS, CDW'(r));
      cfg_write(bmf_pkg::CFG_WIDTH, CDW'(w));
      cfg_write(bmf_pkg::CFG_HEIGHT, CDW'(h));
    end else if (order == 1) begin
      cfg_write(bmf_pkg::CFG_HEIGHT, CDW'(h));
      cfg_write(bmf_pkg::CFG_RADIUS, CDW'(r));
      cfg_write(bmf_pkg::CFG_WIDTH, CDW'(w));
    end else begin
      cfg_write(bmf_pkg::CFG_WIDTH, CDW'(w));
      cfg_write(bmf_pkg::CFG_HEIGHT, CDW'(h));
      cfg_write(bmf_pkg::CFG_RADIUS, CDW'(r));
    end
    cfg_done();
  endtask

  // full frame: pixels then drain items; a few drains land in the pixel part and
  // a few pixels in the drain part; stop_at truncates the frame
  task automatic send_frame(int r, int w, int h, int stop_at);
    int ew, eh, er, total, lag;
    ew = (w == 0) ? 1 : (w > bmf_pkg::MAX_WIDTH_DEF) ? bmf_pkg::MAX_WIDTH_DEF : w;
    eh = (h == 0) ? 1 : (h > bmf_pkg::MAX_HEIGHT_DEF) ? bmf_pkg::MAX_HEIGHT_DEF : h;
    er = (r > bmf_pkg::MAX_RADIUS_DEF) ? bmf_pkg::MAX_RADIUS_DEF : r;
    if (er > (ew - 1) / 2) er = (ew - 1) / 2;
    if (er > (eh - 1) / 2) er = (eh - 1) / 2;
    total = ew * eh;
    lag = er * ew + er;
    for (int k = 0; k < total + lag && k < stop_at; k++) begin
      logic drain;
      drain = (k < total) ? ($urandom_range(0, 15) == 0) : ($urandom_range(0, 7) != 0);
      send_pixel(drain, pick_channel(), pick_channel(), pick_channel());
      // hold off mid-frame until every result so far is out
      if ($urandom_range(0, 99) == 0) begin
        stream_done();
        while (pending != 0) @(posedge clk);
      end
    end
  endtask

  initial begin
    int r, w, h, frames, stop_at;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: 4x3 frame radius 1, extreme channels, drain in pixel part,
    // pixel data in drain part, spare register index
    cfg_write(CFG_SPARE, 11'h7FF);
    configure(1, 4, 3);
    send_pixel(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel(1'b0, 16'h0000, 16'h0000, 16'h0000);
    send_pixel(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel(1'b0, 16'hAAAA, 16'h5555, 16'h0001);
    send_pixel(1'b0, 16'h5555, 16'hAAAA, 16'h8000);
    send_pixel(1'b0, 16'hFFFF, 16'h0000, 16'hFFFF);
    send_pixel(1'b0, 16'h0000, 16'hFFFF, 16'h0000);
    send_pixel(1'b0, 16'h0101, 16'h7FFF, 16'hFFFE);
    send_pixel(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel(1'b1, 16'h0000, 16'h0000, 16'h0000);
    send_pixel(1'b0, 16'h00FF, 16'hFF00, 16'h0F0F);
    send_pixel(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);  // drain part, data ignored
    send_pixel(1'b1, 16'h0000, 16'h0000, 16'h0000);
    send_pixel(1'b1, 16'h0000, 16'h0000, 16'h0000);
    send_pixel(1'b0, 16'h1234, 16'h5678, 16'h9ABC);
    send_pixel(1'b1, 16'h0000, 16'h0000, 16'h0000);
    stream_done();
    drain_wait();

    // random phases; large radius and the size extremes mixed in
    while (items_sent < ITEM_GOAL) begin
      frames = 1;
      stop_at = 1 << 30;
      case ($urandom_range(0, 9))
        0: begin r = 15; w = 0; h = $urandom_range(1, 6); frames = 2; end
        1: begin r = $urandom_range(0, 15); w = 11'h7FF; h = 1; stop_at = 40; end
        2: begin r = $urandom_range(0, 15); w = 2; h = 11'h7FF; stop_at = 50; end
        3: begin
          if (!radius_max_done) begin
            r = 8; w = 17; h = 17;
            radius_max_done = 1;
          end else begin
            r = $urandom_range(0, 3); w = $urandom_range(1, 8); h = $urandom_range(1, 8);
          end
        end
        4: begin
          // truncated frame, restarted by the next configuration
          r = $urandom_range(0, 3); w = $urandom_range(1, 8); h = $urandom_range(1, 8);
          stop_at = $urandom_range(1, 40);
        end
        default: begin
          r = $urandom_range(0, 3); w = $urandom_range(1, 8); h = $urandom_range(1, 8);
          frames = $urandom_range(1, 3);
        end
      endcase
      configure(r, w, h);
      repeat (frames) send_frame(r, w, h, stop_at);
      stream_done();
      drain_wait();
    end

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
